### rtl/load_cell_calibrate_and_weigh_assert.svh
// assertion macros for the load cell front end
// LCW_ASSERT_IMP checks a consequent in the same cycle, LCW_ASSERT_NXT in the next cycle
`ifndef LOAD_CELL_CALIBRATE_AND_WEIGH_ASSERT_SVH
`define LOAD_CELL_CALIBRATE_AND_WEIGH_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcw assertion failed");
`define LCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcw assertion failed");
`else
`define LCW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/lcw_pkg.sv
package lcw_pkg;

    // request command codes
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_CAL    = 2'd1,
        CMD_WEIGH  = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [2:0] REG_TARE        = 3'd0;
    localparam logic [2:0] REG_PA_ADC      = 3'd1;
    localparam logic [2:0] REG_PA_KG_INT   = 3'd2;
    localparam logic [2:0] REG_PA_KG_FRAC  = 3'd3;
    localparam logic [2:0] REG_PB_ADC      = 3'd4;
    localparam logic [2:0] REG_PB_KG_INT   = 3'd5;
    localparam logic [2:0] REG_PB_KG_FRAC  = 3'd6;
    localparam logic [2:0] REG_TABLE_VALID = 3'd7;

    // result kinds
    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_CAL    = 1'b1;

    // field widths
    localparam int ADC_W  = 24;
    localparam int INT_W  = 16;
    localparam int FRAC_W = 14;
    localparam int SUM_W  = 28;
    localparam int KG_W   = 30;               // int*10000 + frac fits in 30 bits
    localparam int NUM_W  = KG_W + ADC_W;     // span times delta
    localparam int CFG_W  = 24;

    // fixed point constants
    localparam logic [FRAC_W-1:0] FRAC_ONE  = 14'd10000;
    localparam logic [FRAC_W-1:0] FRAC_MAX  = 14'd9999;
    localparam logic [INT_W-1:0]  INT_MAX   = 16'hFFFF;
    localparam logic [KG_W-1:0]   W_LIMIT   = 30'd655359999;
    // ceil(2^44 / 10000): exact quotient for any 30 bit dividend
    localparam int                RECIP_SHIFT = 44;
    localparam logic [30:0]       RECIP_M     = 31'd1759218605;

    typedef struct packed {
        cmd_t              command;
        logic [ADC_W-1:0]  sample;
        logic [INT_W-1:0]  ref_kg_int;
        logic [FRAC_W-1:0] ref_kg_frac;
        logic              repeat_req;
    } req_t;

    typedef struct packed {
        logic              kind;
        logic [INT_W-1:0]  kg_int;
        logic [FRAC_W-1:0] kg_frac;
        logic [ADC_W-1:0]  avg_adc;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic cal_init;
        logic cal_acc;
        logic w_latch;
        logic w_prep;
        logic w_span;
        logic div_start_cal;
        logic div_start_w;
        logic w_recip;
        logic w_rem;
        logic out_load_cal;
        logic out_load_w;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic table_valid;
        logic div_busy;
        logic null_result;
        logic out_free;
    } ctl_sts_t;

endpackage

### rtl/load_cell_calibrate_and_weigh.sv
// load cell front end: trimmed mean calibration and two-point weighing
// request channel (req_valid / req_stall / req) carries commands: sample,
// start calibrate with a reference mass, start weigh (single or repeat), stop
// result channel (rsp_valid / rsp_stall / rsp) carries weight readings and
// calibration results; configuration is a plain write port (cfg_we, cfg_index,
// cfg_data) used only while the block is idle
// start, stop and non-final samples are taken with no result, and the block stays idle
// a weigh sample passes the prep, span and mul setup states, the bit-serial
// divide (54 quotient bits, one per cycle), the recip and rem states that
// split kg, and then loads the output once the output register is free
// a sample that reads as zero skips the divide and goes from the mul state
// straight to loading the output; the last calibration sample shows its
// result after a pass through the same divider
// one request is worked on at a time; req_stall is high while it is busy and
// the next request is taken in the cycle after the result is loaded
// the result sits in an output register, so a stalled receiver only holds the
// block once a second result is ready
// reset clears the mode, the configuration registers and the accumulators,
// and drops any pending result
`include "load_cell_calibrate_and_weigh_assert.svh"

module load_cell_calibrate_and_weigh
#(
    parameter int SAMPLE_COUNT = 10,
    parameter int ADC_BITS     = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  lcw_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output lcw_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [lcw_pkg::CFG_W-1:0] cfg_data
);

    lcw_pkg::ctl_cmd_t cmd;
    lcw_pkg::ctl_sts_t sts;

    lcw_ctrl
    #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_command (req.command),
        .req_repeat  (req.repeat_req),
        .sts         (sts),
        .cmd         (cmd)
    );

    lcw_dp
    #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .ADC_BITS     (ADC_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // divider runs after every start, and no request is taken during a divide
    `LCW_ASSERT_NXT(a_div_starts, clk, rst_n, cmd.div_start_cal || cmd.div_start_w, sts.div_busy)
    `LCW_ASSERT_IMP(a_no_req_in_div, clk, rst_n, sts.div_busy, req_stall)
    // a loaded result shows on the result channel
    `LCW_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.out_load_cal || cmd.out_load_w, rsp_valid)

endmodule

### rtl/lcw_div.sv
module lcw_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcw_pkg::NUM_W-1:0]   num,
    input  logic [lcw_pkg::ADC_W-1:0]   den,
    output logic                        busy,
    output logic [lcw_pkg::NUM_W-1:0]   quot
);

    localparam int CNT_W = $clog2(lcw_pkg::NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lcw_pkg::NUM_W - 1);

    logic                        busy_reg, busy_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [lcw_pkg::NUM_W-1:0]   quot_reg, quot_next;
    logic [lcw_pkg::ADC_W-1:0]   rem_reg, rem_next;
    logic [lcw_pkg::ADC_W-1:0]   den_reg, den_next;
    logic [lcw_pkg::ADC_W:0]     trial;
    logic                        fits;

    // one restoring step per cycle, msb first
    always_comb
    begin
        trial     = {rem_reg, quot_reg[lcw_pkg::NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[lcw_pkg::NUM_W-2:0], fits};
            rem_next  = fits ? lcw_pkg::ADC_W'(trial - {1'b0, den_reg})
                             : trial[lcw_pkg::ADC_W-1:0];
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

### rtl/lcw_dp.sv
module lcw_dp
#(
    parameter int SAMPLE_COUNT = 10,
    parameter int ADC_BITS     = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [lcw_pkg::CFG_W-1:0]     cfg_data,
    input  lcw_pkg::req_t                 req,
    input  lcw_pkg::ctl_cmd_t             cmd,
    output lcw_pkg::ctl_sts_t             sts,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lcw_pkg::rsp_t                 rsp
);

    localparam int EFF_BITS = (ADC_BITS < lcw_pkg::ADC_W) ? ADC_BITS : lcw_pkg::ADC_W;
    localparam logic [lcw_pkg::ADC_W-1:0] SAMPLE_MASK =
        lcw_pkg::ADC_W'((33'd1 << EFF_BITS) - 33'd1);
    localparam logic [lcw_pkg::ADC_W-1:0] CAL_DIV = lcw_pkg::ADC_W'(SAMPLE_COUNT - 2);

    // configuration registers
    logic [lcw_pkg::ADC_W-1:0]  tare_reg, pa_adc_reg, pb_adc_reg;
    logic [lcw_pkg::INT_W-1:0]  pa_int_reg, pb_int_reg;
    logic [lcw_pkg::FRAC_W-1:0] pa_frac_reg, pb_frac_reg;
    logic                       tv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg    <= '0;
            pa_adc_reg  <= '0;
            pa_int_reg  <= '0;
            pa_frac_reg <= '0;
            pb_adc_reg  <= '0;
            pb_int_reg  <= '0;
            pb_frac_reg <= '0;
            tv_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcw_pkg::REG_TARE:        tare_reg    <= cfg_data[lcw_pkg::ADC_W-1:0];
                lcw_pkg::REG_PA_ADC:      pa_adc_reg  <= cfg_data[lcw_pkg::ADC_W-1:0];
                lcw_pkg::REG_PA_KG_INT:   pa_int_reg  <= cfg_data[lcw_pkg::INT_W-1:0];
                lcw_pkg::REG_PA_KG_FRAC:  pa_frac_reg <= cfg_data[lcw_pkg::FRAC_W-1:0];
                lcw_pkg::REG_PB_ADC:      pb_adc_reg  <= cfg_data[lcw_pkg::ADC_W-1:0];
                lcw_pkg::REG_PB_KG_INT:   pb_int_reg  <= cfg_data[lcw_pkg::INT_W-1:0];
                lcw_pkg::REG_PB_KG_FRAC:  pb_frac_reg <= cfg_data[lcw_pkg::FRAC_W-1:0];
                lcw_pkg::REG_TABLE_VALID: tv_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [lcw_pkg::ADC_W-1:0] s_masked;
    assign s_masked = req.sample & SAMPLE_MASK;

    // calibration accumulators
    logic [lcw_pkg::SUM_W-1:0]  sum_reg;
    logic [lcw_pkg::ADC_W-1:0]  max_reg, min_reg;
    logic [lcw_pkg::INT_W-1:0]  held_int_reg;
    logic [lcw_pkg::FRAC_W-1:0] held_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            held_int_reg  <= '0;
            held_frac_reg <= '0;
        end
        else if (cmd.cal_init)
        begin
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            held_int_reg  <= req.ref_kg_int;
            held_frac_reg <= req.ref_kg_frac;
        end
        else if (cmd.cal_acc)
        begin
            sum_reg <= sum_reg + lcw_pkg::SUM_W'(s_masked);
            if (s_masked > max_reg)
            begin
                max_reg <= s_masked;
            end
            if (s_masked < min_reg)
            begin
                min_reg <= s_masked;
            end
        end
    end

    logic [lcw_pkg::SUM_W-1:0] cal_num;
    assign cal_num = sum_reg - lcw_pkg::SUM_W'(max_reg) - lcw_pkg::SUM_W'(min_reg);

    // weighing pipeline registers
    logic [lcw_pkg::ADC_W-1:0] s_reg, zero_reg, dcal_reg, delta_reg;
    logic [lcw_pkg::KG_W-1:0]  lo_kg_reg, hi_kg_reg, span_reg, w30_reg;
    logic                      null_reg, sat_reg;
    logic [lcw_pkg::INT_W-1:0] q_reg;
    logic [lcw_pkg::FRAC_W-1:0] frac_reg;

    logic                      b_upper;
    logic [lcw_pkg::ADC_W-1:0] lo_adc, hi_adc;
    logic [lcw_pkg::KG_W-1:0]  a_kg, b_kg;
    logic [lcw_pkg::KG_W:0]    span;
    logic [lcw_pkg::NUM_W-1:0] prod;
    logic [lcw_pkg::NUM_W-1:0] quot;
    logic [60:0]               rprod;

    // combined kg values and lower / upper point selection
    always_comb
    begin
        b_upper = pb_adc_reg >= pa_adc_reg;
        lo_adc  = b_upper ? pa_adc_reg : pb_adc_reg;
        hi_adc  = b_upper ? pb_adc_reg : pa_adc_reg;
        a_kg    = lcw_pkg::KG_W'(pa_int_reg) * lcw_pkg::KG_W'(lcw_pkg::FRAC_ONE)
                  + lcw_pkg::KG_W'(pa_frac_reg);
        b_kg    = lcw_pkg::KG_W'(pb_int_reg) * lcw_pkg::KG_W'(lcw_pkg::FRAC_ONE)
                  + lcw_pkg::KG_W'(pb_frac_reg);
        span    = {1'b0, hi_kg_reg} - {1'b0, lo_kg_reg};
        prod    = lcw_pkg::NUM_W'(span_reg) * lcw_pkg::NUM_W'(delta_reg);
        rprod   = 61'(quot[lcw_pkg::KG_W-1:0]) * 61'(lcw_pkg::RECIP_M);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.w_latch)
        begin
            s_reg <= s_masked;
        end
        if (cmd.w_prep)
        begin
            zero_reg  <= (tare_reg != '0) ? tare_reg : lo_adc;
            dcal_reg  <= hi_adc - lo_adc;
            lo_kg_reg <= b_upper ? a_kg : b_kg;
            hi_kg_reg <= b_upper ? b_kg : a_kg;
        end
        if (cmd.w_span)
        begin
            // at or below zero, flat table, or negative or zero span all read as zero
            null_reg  <= (s_reg <= zero_reg) || (dcal_reg == '0)
                         || span[lcw_pkg::KG_W] || (span == '0);
            span_reg  <= span[lcw_pkg::KG_W-1:0];
            delta_reg <= s_reg - zero_reg;
        end
        if (cmd.w_recip)
        begin
            sat_reg <= quot > lcw_pkg::NUM_W'(lcw_pkg::W_LIMIT);
            w30_reg <= quot[lcw_pkg::KG_W-1:0];
            q_reg   <= rprod[lcw_pkg::RECIP_SHIFT +: lcw_pkg::INT_W];
        end
        if (cmd.w_rem)
        begin
            frac_reg <= lcw_pkg::FRAC_W'(w30_reg - lcw_pkg::KG_W'(q_reg)
                                        * lcw_pkg::KG_W'(lcw_pkg::FRAC_ONE));
        end
    end

    // shared divider: weight over adc span, or trimmed sum over count minus two
    logic                      div_start, div_busy;
    logic [lcw_pkg::NUM_W-1:0] div_num;
    logic [lcw_pkg::ADC_W-1:0] div_den;

    assign div_start = cmd.div_start_cal || cmd.div_start_w;
    assign div_num   = cmd.div_start_w ? prod : lcw_pkg::NUM_W'(cal_num);
    assign div_den   = cmd.div_start_w ? dcal_reg : CAL_DIV;

    lcw_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot)
    );

    // output register
    logic          rsp_valid_reg, rsp_valid_next;
    lcw_pkg::rsp_t rsp_reg, rsp_next;
    logic          out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (cmd.out_load_cal)
        begin
            rsp_valid_next   = 1'b1;
            rsp_next.kind    = lcw_pkg::KIND_CAL;
            rsp_next.kg_int  = held_int_reg;
            rsp_next.kg_frac = held_frac_reg;
            rsp_next.avg_adc = quot[lcw_pkg::ADC_W-1:0];
        end
        else if (cmd.out_load_w)
        begin
            rsp_valid_next   = 1'b1;
            rsp_next.kind    = lcw_pkg::KIND_WEIGHT;
            rsp_next.avg_adc = '0;
            if (null_reg)
            begin
                rsp_next.kg_int  = '0;
                rsp_next.kg_frac = '0;
            end
            else if (sat_reg)
            begin
                rsp_next.kg_int  = lcw_pkg::INT_MAX;
                rsp_next.kg_frac = lcw_pkg::FRAC_MAX;
            end
            else
            begin
                rsp_next.kg_int  = q_reg;
                rsp_next.kg_frac = frac_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;
    assign sts.table_valid = tv_reg;
    assign sts.div_busy    = div_busy;
    assign sts.null_result = null_reg;
    assign sts.out_free    = out_free;

endmodule

### rtl/lcw_ctrl.sv
module lcw_ctrl
#(
    parameter int SAMPLE_COUNT = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  lcw_pkg::cmd_t        req_command,
    input  logic                 req_repeat,
    input  lcw_pkg::ctl_sts_t    sts,
    output lcw_pkg::ctl_cmd_t    cmd
);

    localparam int LEFT_W = $clog2(SAMPLE_COUNT + 1);
    localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(SAMPLE_COUNT);
    localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_CAL_SUB = 11'b000_0000_0010,
        S_CDIV    = 11'b000_0000_0100,
        S_OUT_CAL = 11'b000_0000_1000,
        S_W_PREP  = 11'b000_0001_0000,
        S_W_SPAN  = 11'b000_0010_0000,
        S_W_MUL   = 11'b000_0100_0000,
        S_WDIV    = 11'b000_1000_0000,
        S_W_RECIP = 11'b001_0000_0000,
        S_W_REM   = 11'b010_0000_0000,
        S_OUT_W   = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CAL   = 2'd1,
        MODE_WEIGH = 2'd2
    } mode_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic              cont_reg, cont_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              accept;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cont_next  = cont_reg;
        left_next  = left_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // request decode
                if (accept)
                begin
                    unique case (req_command)
                        lcw_pkg::CMD_CAL:
                        begin
                            cmd.cal_init = 1'b1;
                            left_next    = LEFT_INIT;
                            mode_next    = MODE_CAL;
                        end
                        lcw_pkg::CMD_WEIGH:
                        begin
                            cont_next = req_repeat;
                            mode_next = MODE_WEIGH;
                        end
                        lcw_pkg::CMD_STOP:
                        begin
                            cont_next = 1'b0;
                            mode_next = MODE_IDLE;
                        end
                        lcw_pkg::CMD_SAMPLE:
                        begin
                            if (mode_reg == MODE_CAL)
                            begin
                                cmd.cal_acc = 1'b1;
                                if (left_reg > LEFT_ONE)
                                begin
                                    left_next = left_reg - LEFT_ONE;
                                end
                                else
                                begin
                                    left_next  = '0;
                                    mode_next  = MODE_IDLE;
                                    state_next = S_CAL_SUB;
                                end
                            end
                            else if (mode_reg == MODE_WEIGH)
                            begin
                                if (sts.table_valid)
                                begin
                                    cmd.w_latch = 1'b1;
                                    state_next  = S_W_PREP;
                                end
                                if (!cont_reg)
                                begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CAL_SUB:
            begin
                cmd.div_start_cal = 1'b1;
                state_next        = S_CDIV;
            end
            S_CDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_OUT_CAL;
                end
            end
            S_OUT_CAL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_cal = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_W_PREP:
            begin
                cmd.w_prep = 1'b1;
                state_next = S_W_SPAN;
            end
            S_W_SPAN:
            begin
                cmd.w_span = 1'b1;
                state_next = S_W_MUL;
            end
            S_W_MUL:
            begin
                // zero readings skip the divide
                if (sts.null_result)
                begin
                    state_next = S_OUT_W;
                end
                else
                begin
                    cmd.div_start_w = 1'b1;
                    state_next      = S_WDIV;
                end
            end
            S_WDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_W_RECIP;
                end
            end
            S_W_RECIP:
            begin
                cmd.w_recip = 1'b1;
                state_next  = S_W_REM;
            end
            S_W_REM:
            begin
                cmd.w_rem  = 1'b1;
                state_next = S_OUT_W;
            end
            S_OUT_W:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_w = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_IDLE;
            cont_reg  <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cont_reg  <= cont_next;
            left_reg  <= left_next;
        end
    end

endmodule

### dv/load_cell_calibrate_and_weigh_tb.sv
`timescale 1ns / 100ps

module load_cell_calibrate_and_weigh_tb;

    localparam int CLK_PERIOD     = 4;
    localparam int N_CAL          = 10;
    localparam int SETTLE_CYCLES  = 120;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int ITEMS_PER_SET  = 48;
    localparam int N_SETTINGS     = 10;

    // how a request's result is known
    typedef enum logic [1:0] {
        OUT_MODEL,
        OUT_NONE,
        OUT_VALUE
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAL,
        ST_WEIGH
    } run_mode_t;

    typedef struct packed {
        lcw_pkg::req_t r;
        outcome_t      how;
        lcw_pkg::rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    lcw_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    lcw_pkg::rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [lcw_pkg::CFG_W-1:0] cfg_data = '0;

    // shadow of the calibration table
    logic [23:0] c_tare, c_pa_adc, c_pb_adc;
    logic [15:0] c_pa_int, c_pb_int;
    logic [13:0] c_pa_frac, c_pb_frac;
    logic        c_valid;

    // shadow of the front end state
    run_mode_t   m_mode;
    logic [3:0]  m_left;
    logic [27:0] m_sum;
    logic [23:0] m_max, m_min;
    logic [15:0] m_ref_int;
    logic [13:0] m_ref_frac;
    logic        m_cont;

    logic [lcw_pkg::CFG_W-1:0] cfg_plan [0:7];
    lcw_pkg::rsp_t pending_rsp [$];
    dir_row_t      dir_rows [$];
    lcw_pkg::rsp_t want_rsp;
    int         mismatches = 0;
    int         work_items = 0;
    int         burst_left = 0;
    int         gap_max = 0;
    int         stall_pct = 0;
    int         stall_left = 0;

    load_cell_calibrate_and_weigh #(
        .SAMPLE_COUNT (N_CAL),
        .ADC_BITS     (24)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // guard against a hung block
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    function automatic lcw_pkg::req_t mk_req(input lcw_pkg::cmd_t c, input logic [23:0] s,
                                             input logic [15:0] ki, input logic [13:0] kf,
                                             input logic rep);
        lcw_pkg::req_t r;
        r.command     = c;
        r.sample      = s;
        r.ref_kg_int  = ki;
        r.ref_kg_frac = kf;
        r.repeat_req  = rep;
        return r;
    endfunction

    function automatic lcw_pkg::rsp_t mk_rsp(input logic k, input logic [15:0] ki,
                                             input logic [13:0] kf, input logic [23:0] avg);
        lcw_pkg::rsp_t y;
        y.kind    = k;
        y.kg_int  = ki;
        y.kg_frac = kf;
        y.avg_adc = avg;
        return y;
    endfunction

    // two-point line from adc reading to kg, in ten-thousandths
    function automatic lcw_pkg::rsp_t calc_weight(input logic [23:0] s);
        logic [23:0] lo_adc, hi_adc, zero, delta, dcal;
        longint lo_kg, hi_kg, span;
        longint unsigned w;
        lcw_pkg::rsp_t y;
        y = mk_rsp(lcw_pkg::KIND_WEIGHT, '0, '0, '0);
        if (c_pb_adc >= c_pa_adc)
        begin
            lo_adc = c_pa_adc;
            hi_adc = c_pb_adc;
            lo_kg  = c_pa_int * 64'd10000 + c_pa_frac;
            hi_kg  = c_pb_int * 64'd10000 + c_pb_frac;
        end
        else
        begin
            lo_adc = c_pb_adc;
            hi_adc = c_pa_adc;
            lo_kg  = c_pb_int * 64'd10000 + c_pb_frac;
            hi_kg  = c_pa_int * 64'd10000 + c_pa_frac;
        end
        zero = (c_tare != '0) ? c_tare : lo_adc;
        span = hi_kg - lo_kg;
        if (s <= zero || hi_adc == lo_adc || span <= 0)
            return y;
        delta = s - zero;
        dcal  = hi_adc - lo_adc;
        w = (longint'(span) * delta) / dcal;
        if (w / 10000 > 65535)
        begin
            y.kg_int  = lcw_pkg::INT_MAX;
            y.kg_frac = lcw_pkg::FRAC_MAX;
        end
        else
        begin
            y.kg_int  = 16'(w / 10000);
            y.kg_frac = 14'(w % 10000);
        end
        return y;
    endfunction

    // advance the front end by one request; returns 1 when a result is due
    function automatic bit apply_request(input lcw_pkg::req_t r, output lcw_pkg::rsp_t y);
        logic [27:0] trimmed;
        y = '0;
        case (r.command)
            lcw_pkg::CMD_CAL:
            begin
                m_ref_int  = r.ref_kg_int;
                m_ref_frac = r.ref_kg_frac;
                m_left     = 4'(N_CAL);
                m_sum      = '0;
                m_max      = '0;
                m_min      = '1;
                m_mode     = ST_CAL;
                return 1'b0;
            end
            lcw_pkg::CMD_WEIGH:
            begin
                m_cont = r.repeat_req;
                m_mode = ST_WEIGH;
                return 1'b0;
            end
            lcw_pkg::CMD_STOP:
            begin
                m_cont = 1'b0;
                m_mode = ST_IDLE;
                return 1'b0;
            end
            default: ;
        endcase
        if (m_mode == ST_CAL)
        begin
            m_sum = m_sum + 28'(r.sample);
            if (r.sample > m_max)
                m_max = r.sample;
            if (r.sample < m_min)
                m_min = r.sample;
            if (m_left > 4'd1)
            begin
                m_left = m_left - 4'd1;
                return 1'b0;
            end
            m_left  = '0;
            trimmed = m_sum - 28'(m_max) - 28'(m_min);
            m_mode  = ST_IDLE;
            y = mk_rsp(lcw_pkg::KIND_CAL, m_ref_int, m_ref_frac,
                       24'(trimmed / 28'(N_CAL - 2)));
            return 1'b1;
        end
        if (m_mode == ST_WEIGH)
        begin
            if (!m_cont)
                m_mode = ST_IDLE;
            if (c_valid)
            begin
                y = calc_weight(r.sample);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // drive one request and book its expected result once it is taken
    task automatic send_request(input lcw_pkg::req_t r, input outcome_t how,
                                input lcw_pkg::rsp_t want);
        lcw_pkg::rsp_t y;
        bit   due;
        int   gap;
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (!(r.command == lcw_pkg::CMD_SAMPLE && m_mode == ST_IDLE))
            work_items++;
        due = apply_request(r, y);
        if (how == OUT_VALUE)
            pending_rsp.push_back(want);
        else if (how == OUT_MODEL && due)
            pending_rsp.push_back(y);
        // bursts separated by random gaps
        if (burst_left == 0)
        begin
            burst_left = int'($urandom_range(1, 24));
            gap = (gap_max == 0) ? 0 : int'($urandom_range(1, gap_max));
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // hold off until every expected result is in
    task automatic wait_results(input bit settle);
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_rsp.size() != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the whole calibration table from cfg_plan
    task automatic load_table();
        logic [lcw_pkg::CFG_W-1:0] d;
        for (int i = 0; i < 8; i++)
        begin
            d = cfg_plan[i];
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= d;
            @(posedge clk);
            case (3'(i))
                lcw_pkg::REG_TARE:        c_tare    = d[23:0];
                lcw_pkg::REG_PA_ADC:      c_pa_adc  = d[23:0];
                lcw_pkg::REG_PA_KG_INT:   c_pa_int  = d[15:0];
                lcw_pkg::REG_PA_KG_FRAC:  c_pa_frac = d[13:0];
                lcw_pkg::REG_PB_ADC:      c_pb_adc  = d[23:0];
                lcw_pkg::REG_PB_KG_INT:   c_pb_int  = d[15:0];
                lcw_pkg::REG_PB_KG_FRAC:  c_pb_frac = d[13:0];
                lcw_pkg::REG_TABLE_VALID: c_valid   = d[0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // calibration table for one setting of the random part
    task automatic plan_table(input int setting);
        logic [23:0] lo_adc, hi_adc;
        logic [15:0] lo_int, hi_int;
        lo_adc = 24'($urandom_range(0, 2000000));
        hi_adc = lo_adc + 24'($urandom_range(1000, 8000000));
        lo_int = 16'($urandom_range(0, 20));
        hi_int = lo_int + 16'($urandom_range(1, 2000));
        cfg_plan[lcw_pkg::REG_TARE]        = '0;
        cfg_plan[lcw_pkg::REG_PA_ADC]      = lo_adc;
        cfg_plan[lcw_pkg::REG_PA_KG_INT]   = lcw_pkg::CFG_W'(lo_int);
        cfg_plan[lcw_pkg::REG_PA_KG_FRAC]  = lcw_pkg::CFG_W'($urandom_range(0, 9999));
        cfg_plan[lcw_pkg::REG_PB_ADC]      = hi_adc;
        cfg_plan[lcw_pkg::REG_PB_KG_INT]   = lcw_pkg::CFG_W'(hi_int);
        cfg_plan[lcw_pkg::REG_PB_KG_FRAC]  = lcw_pkg::CFG_W'($urandom_range(0, 9999));
        cfg_plan[lcw_pkg::REG_TABLE_VALID] = lcw_pkg::CFG_W'(1);
        case (setting)
            // tare above the lower point
            1: cfg_plan[lcw_pkg::REG_TARE] = lo_adc + 24'($urandom_range(1, 50000));
            // point b below point a
            2:
            begin
                cfg_plan[lcw_pkg::REG_PA_ADC]    = hi_adc;
                cfg_plan[lcw_pkg::REG_PB_ADC]    = lo_adc;
                cfg_plan[lcw_pkg::REG_PA_KG_INT] = lcw_pkg::CFG_W'(hi_int);
                cfg_plan[lcw_pkg::REG_PB_KG_INT] = lcw_pkg::CFG_W'(lo_int);
            end
            // mass falls as the reading rises
            3:
            begin
                cfg_plan[lcw_pkg::REG_PA_KG_INT] = lcw_pkg::CFG_W'(hi_int);
                cfg_plan[lcw_pkg::REG_PB_KG_INT] = lcw_pkg::CFG_W'(lo_int);
            end
            // both points at the same reading
            4: cfg_plan[lcw_pkg::REG_PB_ADC] = lo_adc;
            // steep line that saturates
            5:
            begin
                cfg_plan[lcw_pkg::REG_PA_ADC]     = '0;
                cfg_plan[lcw_pkg::REG_PB_ADC]     = lcw_pkg::CFG_W'($urandom_range(1, 16));
                cfg_plan[lcw_pkg::REG_PA_KG_INT]  = '0;
                cfg_plan[lcw_pkg::REG_PA_KG_FRAC] = '0;
                cfg_plan[lcw_pkg::REG_PB_KG_INT]  = lcw_pkg::CFG_W'(16'hFFFF);
                cfg_plan[lcw_pkg::REG_PB_KG_FRAC] = lcw_pkg::CFG_W'(14'h3FFF);
            end
            6:
                for (int i = 0; i < 8; i++)
                    cfg_plan[i] = '1;
            // empty table, weighing gives nothing
            7:
                for (int i = 0; i < 8; i++)
                    cfg_plan[i] = '0;
            8:
                for (int i = 0; i < 8; i++)
                    cfg_plan[i] = lcw_pkg::CFG_W'($urandom);
            // fractions past 9999
            9:
            begin
                cfg_plan[lcw_pkg::REG_PA_KG_FRAC] = lcw_pkg::CFG_W'($urandom_range(10000, 16383));
                cfg_plan[lcw_pkg::REG_PB_KG_FRAC] = lcw_pkg::CFG_W'($urandom_range(10000, 16383));
            end
            default: ;
        endcase
    endtask

    // weigh sample, mostly around the calibrated range
    function automatic logic [23:0] pick_sample();
        logic [23:0] lo, hi;
        lo = (c_pa_adc < c_pb_adc) ? c_pa_adc : c_pb_adc;
        hi = (c_pa_adc < c_pb_adc) ? c_pb_adc : c_pa_adc;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return 24'($urandom);
            default: return lo + 24'($urandom_range(0, hi - lo + 4096)) - 24'd2048;
        endcase
    endfunction

    function automatic logic [13:0] pick_frac();
        if ($urandom_range(0, 4) == 0)
            return 14'($urandom_range(10000, 16383));
        return 14'($urandom_range(0, 9999));
    endfunction

    task automatic add_row(input lcw_pkg::cmd_t c, input logic [23:0] s,
                           input logic [15:0] ki, input logic [13:0] kf, input logic rep,
                           input outcome_t how, input lcw_pkg::rsp_t want);
        dir_row_t row;
        row.r    = mk_req(c, s, ki, kf, rep);
        row.how  = how;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // receiver stalls in windows of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= int'($urandom_range(0, 15));
            rsp_stall  <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, rsp);
                mismatches++;
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                check_field("kind", want_rsp.kind, rsp.kind);
                check_field("kg_int", want_rsp.kg_int, rsp.kg_int);
                check_field("kg_frac", want_rsp.kg_frac, rsp.kg_frac);
                check_field("avg_adc", want_rsp.avg_adc, rsp.avg_adc);
            end
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int          choose;
        int          n;
        int          k;
        logic [23:0] center;
        logic        rep;
        bit          broken;

        c_tare = '0;  c_pa_adc = '0;  c_pa_int = '0;  c_pa_frac = '0;
        c_pb_adc = '0;  c_pb_int = '0;  c_pb_frac = '0;  c_valid = 1'b0;
        m_mode = ST_IDLE;  m_left = '0;  m_sum = '0;  m_max = '0;  m_min = '1;
        m_ref_int = '0;  m_ref_frac = '0;  m_cont = 1'b0;

        // reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table first
        add_row(lcw_pkg::CMD_SAMPLE, 24'h123456, '0, '0, 1'b0, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_WEIGH, '0, '0, '0, 1'b0, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_SAMPLE, 24'd5000, '0, '0, 1'b0, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_SAMPLE, 24'd5000, '0, '0, 1'b0, OUT_NONE, '0);
        // line from 1000 -> 0 kg to 11000 -> 10 kg
        add_row(lcw_pkg::CMD_WEIGH, '0, '0, '0, 1'b1, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_SAMPLE, '0, '1, '1, 1'b1, OUT_VALUE,
                mk_rsp(lcw_pkg::KIND_WEIGHT, 16'd0, 14'd0, 24'd0));
        add_row(lcw_pkg::CMD_SAMPLE, 24'd1000, '0, '0, 1'b0, OUT_VALUE,
                mk_rsp(lcw_pkg::KIND_WEIGHT, 16'd0, 14'd0, 24'd0));
        add_row(lcw_pkg::CMD_SAMPLE, 24'd6000, '0, '0, 1'b0, OUT_MODEL, '0);
        add_row(lcw_pkg::CMD_SAMPLE, '1, '0, '0, 1'b0, OUT_MODEL, '0);
        add_row(lcw_pkg::CMD_STOP, '1, '1, '1, 1'b1, OUT_NONE, '0);
        // calibration with reference at the field extremes
        add_row(lcw_pkg::CMD_CAL, '1, '1, '1, 1'b1, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_SAMPLE, '0, '0, '0, 1'b0, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_SAMPLE, '1, '0, '0, 1'b0, OUT_NONE, '0);
        for (int i = 0; i < N_CAL - 3; i++)
            add_row(lcw_pkg::CMD_SAMPLE, 24'd800, '0, '0, 1'b0, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_SAMPLE, 24'd800, '0, '0, 1'b0, OUT_VALUE,
                mk_rsp(lcw_pkg::KIND_CAL, 16'hFFFF, 14'h3FFF, 24'd800));
        // a weigh command abandons a calibration, single weigh ends after one reading
        add_row(lcw_pkg::CMD_CAL, '0, '0, '0, 1'b0, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_WEIGH, '0, '0, '0, 1'b0, OUT_NONE, '0);
        add_row(lcw_pkg::CMD_SAMPLE, 24'd11000, '0, '0, 1'b0, OUT_VALUE,
                mk_rsp(lcw_pkg::KIND_WEIGHT, 16'd10, 14'd0, 24'd0));
        add_row(lcw_pkg::CMD_SAMPLE, 24'd6000, '0, '0, 1'b0, OUT_NONE, '0);

        foreach (dir_rows[i])
        begin
            if (i == 4)
            begin
                wait_results(1'b1);
                cfg_plan[lcw_pkg::REG_TARE]        = '0;
                cfg_plan[lcw_pkg::REG_PA_ADC]      = 24'd1000;
                cfg_plan[lcw_pkg::REG_PA_KG_INT]   = 24'd0;
                cfg_plan[lcw_pkg::REG_PA_KG_FRAC]  = 24'd0;
                cfg_plan[lcw_pkg::REG_PB_ADC]      = 24'd11000;
                cfg_plan[lcw_pkg::REG_PB_KG_INT]   = 24'd10;
                cfg_plan[lcw_pkg::REG_PB_KG_FRAC]  = 24'd0;
                cfg_plan[lcw_pkg::REG_TABLE_VALID] = 24'd1;
                load_table();
            end
            send_request(dir_rows[i].r, dir_rows[i].how, dir_rows[i].want);
        end

        // random part, one table setting at a time
        for (int setting = 0; setting < N_SETTINGS; setting++)
        begin
            wait_results(1'b1);
            plan_table(setting);
            load_table();
            gap_max   = (setting % 4 == 0) ? 0 : 12;
            stall_pct = (setting % 4 == 0) ? 0 : ((setting % 2 == 1) ? 30 : 70);
            work_items = 0;
            while (work_items < ITEMS_PER_SET)
            begin
                choose = int'($urandom_range(0, 99));
                if (choose < 35)
                begin
                    // calibration run, sometimes cut short
                    broken = ($urandom_range(0, 9) == 0);
                    n = broken ? int'($urandom_range(1, N_CAL - 1)) : N_CAL;
                    center = 24'($urandom);
                    send_request(mk_req(lcw_pkg::CMD_CAL, 24'($urandom), 16'($urandom),
                                        pick_frac(), 1'($urandom_range(0, 1))),
                                 OUT_MODEL, '0);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            send_request(mk_req(lcw_pkg::CMD_SAMPLE, 24'($urandom),
                                                16'($urandom), 14'($urandom),
                                                1'($urandom_range(0, 1))), OUT_MODEL, '0);
                        else
                            send_request(mk_req(lcw_pkg::CMD_SAMPLE,
                                                center + 24'($urandom_range(0, 4000))
                                                - 24'd2000,
                                                16'($urandom), 14'($urandom), 1'b0),
                                         OUT_MODEL, '0);
                    end
                    if (broken && $urandom_range(0, 1))
                        send_request(mk_req(lcw_pkg::CMD_STOP, 24'($urandom), 16'($urandom),
                                            14'($urandom), 1'($urandom_range(0, 1))),
                                     OUT_MODEL, '0);
                end
                else if (choose < 85)
                begin
                    // weighing, single or continuous
                    rep = 1'($urandom_range(0, 1));
                    k = rep ? int'($urandom_range(1, 8)) : 1;
                    send_request(mk_req(lcw_pkg::CMD_WEIGH, 24'($urandom), 16'($urandom),
                                        14'($urandom), rep), OUT_MODEL, '0);
                    repeat (k)
                        send_request(mk_req(lcw_pkg::CMD_SAMPLE, pick_sample(),
                                            16'($urandom), 14'($urandom),
                                            1'($urandom_range(0, 1))), OUT_MODEL, '0);
                    if (rep && $urandom_range(0, 1))
                        send_request(mk_req(lcw_pkg::CMD_STOP, 24'($urandom), 16'($urandom),
                                            14'($urandom), 1'($urandom_range(0, 1))),
                                     OUT_MODEL, '0);
                end
                else if (choose < 96)
                begin
                    // noise
                    send_request(mk_req(lcw_pkg::cmd_t'($urandom_range(0, 3)),
                                        24'($urandom), 16'($urandom), 14'($urandom),
                                        1'($urandom_range(0, 1))), OUT_MODEL, '0);
                end
                else
                    wait_results(1'b0);
            end
        end

        // wind down
        wait_results(1'b1);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
